// ===== rtl/core/bba_pkg.sv =====
// Shared constants and controller/datapath interface types for the block allocator.
`default_nettype none

package bba_pkg;

  localparam int BLOCKS_DEF      = 256;
  localparam int BLOCK_BYTES_DEF = 2048;
  localparam int ROW_BITS        = 32;
  localparam int PCT_SCALE       = 100;

  localparam logic [31:0] HEAP_BASE_RST = 32'h0010_0000;

  localparam logic REG_HEAP_BASE = 1'b0;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic rd_alloc;
    logic rd_free;
    logic ptr_inc;
    logic wr_alloc;
    logic wr_free;
    logic div_idx;
    logic idx_capture;
    logic div_pct;
    logic pct_capture;
    logic mul;
    logic add;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_ok;
    logic full;
    logic free_ok;
    logic row_hit;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bba_div.sv =====
// Constant divider by reciprocal multiplication; quotient and done are registered from start.
`default_nettype none

module bba_div #(
  parameter int     NW      = 19,
  parameter int     QW      = 8,
  parameter longint DIVISOR = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int            SH    = NW + $clog2(DIVISOR);
  localparam longint        RCP   = ((longint'(1) << SH) + DIVISOR - 1) / DIVISOR;
  localparam int            MW    = NW + 2;
  localparam int            PW    = NW + MW;
  localparam logic [MW-1:0] RCP_W = MW'(RCP);

  logic [PW-1:0] prod;

  always_comb begin
    prod = PW'(dividend) * PW'(RCP_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= QW'(prod >> SH);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bba_dp.sv =====
// Allocator datapath: bitmap memory, counters, dividers, address math and result register.
`default_nettype none

module bba_dp #(
  parameter int BLOCKS      = bba_pkg::BLOCKS_DEF,
  parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       heap_base,
  input  logic              in_cmd,
  input  logic [31:0]       in_size,
  input  logic [31:0]       in_addr,
  input  bba_pkg::ctrl_cmd_t cmd,
  output bba_pkg::dp_stat_t  stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_done,
  output logic [31:0]       out_addr,
  output logic [7:0]        out_index,
  output logic [8:0]        out_used,
  output logic [6:0]        out_pct
);

  localparam int RB    = bba_pkg::ROW_BITS;
  localparam int ROWS  = (BLOCKS + RB - 1) / RB;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW    = $clog2(RB);
  localparam int XW    = RW + PW;
  localparam int CW    = $clog2(BLOCKS + 1);
  localparam int ONW   = $clog2(longint'(BLOCKS) * longint'(BLOCK_BYTES));
  localparam int PNW   = $clog2(BLOCKS * bba_pkg::PCT_SCALE + 1);
  localparam logic [32:0] LIMIT   = 33'(longint'(BLOCKS) * longint'(BLOCK_BYTES));
  localparam logic [XW:0] BLK_LIM = (XW + 1)'(BLOCKS);

  logic [RB-1:0] bmap [ROWS];
  logic [ROWS-1:0] row_vld;

  logic          req_free;
  logic          size_ok;
  logic          req_nzge;
  logic [31:0]   req_off;
  logic [CW-1:0] used;
  logic [RW-1:0] hint;
  logic [RW-1:0] ptr;
  logic [RB-1:0] rd_data;
  logic          rd_vld;
  logic [RW-1:0] rd_row;
  logic          res_done;
  logic [31:0]   res_addr;
  logic [XW-1:0] res_idx;
  logic [31:0]   prod;
  logic [6:0]    pct;

  logic [RW-1:0] rd_addr;
  logic [RB-1:0] word;
  logic [RB-1:0] pos_mask;
  logic [RB-1:0] free_bits;
  logic [PW-1:0] hit_pos;
  logic [PW-1:0] free_pos;
  logic [RB-1:0] wr_word;

  logic [PNW-1:0] pct_num;
  logic           idx_done;
  logic [XW-1:0]  idx_q;
  logic           pct_done;
  logic [6:0]     pct_q;

  always_comb begin
    rd_addr  = cmd.rd_free ? res_idx[XW-1:PW] : ptr;
    word     = rd_vld ? rd_data : '0;
    free_pos = res_idx[PW-1:0];
    for (int j = 0; j < RB; j++) begin
      pos_mask[j] = {1'b0, rd_row, PW'(j)} < BLK_LIM;
    end
    free_bits = ~word & pos_mask;
    hit_pos   = '0;
    for (int j = RB - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        hit_pos = PW'(j);
      end
    end
    if (cmd.wr_alloc) begin
      wr_word = word | (RB'(1) << hit_pos);
    end else begin
      wr_word = word & ~(RB'(1) << free_pos);
    end
  end

  always_comb begin
    stat.is_free  = req_free == bba_pkg::CMD_FREE;
    stat.size_ok  = size_ok;
    stat.full     = used == CW'(BLOCKS);
    stat.free_ok  = req_nzge && ({1'b0, req_off} < LIMIT);
    stat.row_hit  = |free_bits;
    stat.div_done = idx_done || pct_done;
    stat.out_free = !out_valid || out_ready;
  end

  always_comb begin
    pct_num = PNW'(32'(used) * 32'(bba_pkg::PCT_SCALE));
  end

  bba_div #(
    .NW      (ONW),
    .QW      (XW),
    .DIVISOR (longint'(BLOCK_BYTES))
  ) u_div_idx (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_idx),
    .dividend (req_off[ONW-1:0]),
    .done     (idx_done),
    .quotient (idx_q)
  );

  bba_div #(
    .NW      (PNW),
    .QW      (7),
    .DIVISOR (longint'(BLOCKS))
  ) u_div_pct (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_pct),
    .dividend (pct_num),
    .done     (pct_done),
    .quotient (pct_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_alloc || cmd.rd_free) begin
      rd_data <= bmap[rd_addr];
      rd_vld  <= row_vld[rd_addr];
      rd_row  <= rd_addr;
    end
    if (cmd.wr_alloc || cmd.wr_free) begin
      bmap[rd_row] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld   <= '0;
      used      <= '0;
      hint      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.wr_alloc) begin
        row_vld[rd_row] <= 1'b1;
        used            <= used + 1'b1;
        hint            <= rd_row;
      end
      if (cmd.wr_free) begin
        row_vld[rd_row] <= 1'b1;
        if (word[free_pos]) begin
          used <= used - 1'b1;
        end
        if (rd_row < hint) begin
          hint <= rd_row;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_free <= in_cmd;
      size_ok  <= in_size <= 32'(BLOCK_BYTES);
      req_nzge <= (in_addr != '0) && (in_addr >= heap_base);
      req_off  <= in_addr - heap_base;
      res_done <= 1'b0;
      res_addr <= '0;
      res_idx  <= '0;
    end
    if (cmd.scan_init) begin
      ptr <= hint;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + 1'b1;
    end
    if (cmd.idx_capture) begin
      res_idx <= idx_q;
    end
    if (cmd.wr_alloc) begin
      res_done <= 1'b1;
      res_idx  <= {rd_row, hit_pos};
    end
    if (cmd.wr_free) begin
      res_done <= 1'b1;
    end
    if (cmd.mul) begin
      prod <= 32'(32'(res_idx) * 32'(BLOCK_BYTES));
    end
    if (cmd.add) begin
      res_addr <= heap_base + prod;
    end
    if (cmd.pct_capture) begin
      pct <= pct_q;
    end
    if (cmd.out_load) begin
      out_done  <= res_done;
      out_addr  <= res_addr;
      out_index <= 8'(res_idx);
      out_used  <= 9'(used);
      out_pct   <= pct;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bba_ctrl.sv =====
// Allocator controller state machine.
`default_nettype none

module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bba_pkg::dp_stat_t  stat,
  output bba_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_FRD,
    S_FWR,
    S_ARD,
    S_ACHK,
    S_MUL,
    S_ADD,
    S_PCT,
    S_PWAIT,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_free) begin
          if (stat.free_ok) begin
            cmd.div_idx = 1'b1;
            state_next  = S_DIV;
          end else begin
            state_next = S_PCT;
          end
        end else if (stat.size_ok && !stat.full) begin
          cmd.scan_init = 1'b1;
          state_next    = S_ARD;
        end else begin
          state_next = S_PCT;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.idx_capture = 1'b1;
          state_next      = S_FRD;
        end
      end
      S_FRD: begin
        cmd.rd_free = 1'b1;
        state_next  = S_FWR;
      end
      S_FWR: begin
        cmd.wr_free = 1'b1;
        state_next  = S_PCT;
      end
      S_ARD: begin
        cmd.rd_alloc = 1'b1;
        state_next   = S_ACHK;
      end
      S_ACHK: begin
        if (stat.row_hit) begin
          cmd.wr_alloc = 1'b1;
          state_next   = S_MUL;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_ARD;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_PCT;
      end
      S_PCT: begin
        cmd.div_pct = 1'b1;
        state_next  = S_PWAIT;
      end
      S_PWAIT: begin
        if (stat.div_done) begin
          cmd.pct_capture = 1'b1;
          state_next      = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_block_allocator.sv =====
// Top level of the first-fit bitmap block allocator with its configuration port.
// One item at a time. An allocate scans 1 to ceil(BLOCKS/32) bitmap rows.
// Input ready again in the cycle after the result loads; a stalled result holds the input.
// Synchronous reset empties the bitmap at once (per-row valid bits), zeroes the used
// count and sets heap_base to 0x00100000; no clearing pass.
`default_nettype none

module bitmap_block_allocator #(
  parameter int BLOCKS      = bba_pkg::BLOCKS_DEF,
  parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // request_size, free_addr
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // done_res, block_addr, block_index, used_blocks,
                                     // usage_percent, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] heap_base;
  logic        out_done;
  logic [31:0] out_addr;
  logic [7:0]  out_index;
  logic [8:0]  out_used;
  logic [6:0]  out_pct;

  bba_pkg::ctrl_cmd_t cmd;
  bba_pkg::dp_stat_t  stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= bba_pkg::HEAP_BASE_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == bba_pkg::REG_HEAP_BASE) begin
      heap_base <= pwdata;
    end
  end

  always_comb begin
    prdata = (paddr[2] == bba_pkg::REG_HEAP_BASE) ? heap_base : '0;
  end

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp #(
    .BLOCKS      (BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .heap_base (heap_base),
    .in_cmd    (s_axis_tuser),
    .in_size   (s_axis_tdata[31:0]),
    .in_addr   (s_axis_tdata[63:32]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_done  (out_done),
    .out_addr  (out_addr),
    .out_index (out_index),
    .out_used  (out_used),
    .out_pct   (out_pct)
  );

  assign m_axis_tdata = {7'b0, out_pct, out_used, out_index, out_addr, out_done};

endmodule

`default_nettype wire
